[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, left empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every rising edge, disabled while reset is low.
`define OBM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define OBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OBM_ASSERT(lbl, clk, rst_n, prop, msg)
`define OBM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/core/obm_pkg.sv]
// ----------------------------------------------------------------------------
// obm_pkg
// Shared types and codes of the order book matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package obm_pkg;

  localparam int          MAX_RESULTS = 64;
  localparam int          RES_CNT_W   = 7;

  localparam logic        OP_INSERT = 1'b0;
  localparam logic        OP_MATCH  = 1'b1;

  localparam logic        SIDE_ASK  = 1'b0;
  localparam logic        SIDE_BID  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WALK,
    ST_FLUSH
  } obm_state_e;

endpackage

`default_nettype wire

[rtl/core/obm_ram.sv]
// ----------------------------------------------------------------------------
// obm_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module obm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/core/order_book_matcher.sv]
// ----------------------------------------------------------------------------
// order_book_matcher
// Limit order book: stores orders, matches asks and bids per product and time id.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request per transfer.
//   An insert request writes the order into the order RAM and gives no
//   result; it is dropped once ORDER_SLOTS orders are held. A match
//   request scans the RAM up to the fill count, sorting the hits into an
//   ask row and a bid row of price-ordered cells. The walk then passes the
//   whole bid row once past each ask, rotating it (an ask of zero amount
//   is skipped without a rotation), and ends when either row is empty or
//   MAX_RESULTS sales are made. A flush state follows. Inserts are
//   accepted back to back while no match is running.
//   Output channel (out_valid_o / out_stall_i) carries sales; the last one
//   of a match has last_sale_o set, and an empty match gives one item with
//   sale_valid_o low. A stalled output holds the walk, never drops data.
//   Reset empties the book and clears the output channel; RAM contents are
//   left as they are and only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module order_book_matcher #(
  parameter int ORDER_SLOTS = 32,
  parameter int VALUE_BITS  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic        order_side_i,
  input  wire logic [31:0] order_price_i,
  input  wire logic [31:0] order_amount_i,
  input  wire logic [15:0] product_id_i,
  input  wire logic [31:0] time_id_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      sale_price_o,
  output logic [31:0]      sale_amount_o,
  output logic             sale_valid_o,
  output logic             last_sale_o
);

  import obm_pkg::*;

  localparam int VW   = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int AW   = $clog2(ORDER_SLOTS);
  localparam int CW   = $clog2(ORDER_SLOTS + 1);
  localparam int T_LO = 0;
  localparam int P_LO = 32;
  localparam int A_LO = 48;
  localparam int R_LO = 48 + VW;
  localparam int S_B  = 48 + 2 * VW;
  localparam int EW   = S_B + 1;

  obm_state_e state_q, state_d;

  logic [CW-1:0]        count_q;
  logic [CW-1:0]        rd_cnt_q;
  logic                 rd_v_q;
  logic [15:0]          key_prod_q;
  logic [31:0]          key_time_q;
  logic [CW-1:0]        na_q, nb_q, rot_q;
  logic [RES_CNT_W-1:0] n_q;
  logic                 pend_v_q;
  logic [VW-1:0]        pend_price_q, pend_amt_q;
  logic                 out_valid_q;
  logic [31:0]          out_price_q, out_amt_q;
  logic                 out_sv_q, out_last_q;

  logic [VW-1:0] a_price [ORDER_SLOTS];
  logic [VW-1:0] a_rem   [ORDER_SLOTS];
  logic [VW-1:0] b_price [ORDER_SLOTS];
  logic [VW-1:0] b_rem   [ORDER_SLOTS];

  logic [VW-1:0] a_prv_p [ORDER_SLOTS];
  logic [VW-1:0] a_prv_r [ORDER_SLOTS];
  logic [VW-1:0] a_nxt_p [ORDER_SLOTS];
  logic [VW-1:0] a_nxt_r [ORDER_SLOTS];
  logic [VW-1:0] b_prv_p [ORDER_SLOTS];
  logic [VW-1:0] b_prv_r [ORDER_SLOTS];
  logic [VW-1:0] b_nxt_p [ORDER_SLOTS];
  logic [VW-1:0] b_nxt_r [ORDER_SLOTS];
  logic          a_gt    [ORDER_SLOTS];
  logic          b_lt    [ORDER_SLOTS];
  logic          a_pgt   [ORDER_SLOTS];
  logic          b_plt   [ORDER_SLOTS];

  logic          in_acc;
  logic          ram_we, ram_re;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic          hit, ins_ask, ins_bid;
  logic [VW-1:0] new_price, new_amt;
  logic          out_free, walk_end, walk_en, step, skip_ask, trade, ask_done;
  logic          rotate, advance_ask, flush_go, out_load, match_go;
  logic [VW-1:0] amt, ask_rem_nx, bid_rem_nx;

  assign in_acc = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------- order RAM
  assign ram_we    = in_acc && (operation_i == OP_INSERT) && (count_q < CW'(ORDER_SLOTS));
  assign ram_wdata = {order_side_i, order_price_i[VW-1:0], order_amount_i[VW-1:0],
                      product_id_i, time_id_i};

  obm_ram #(
    .WIDTH (EW),
    .DEPTH (ORDER_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign new_price = ram_rdata[R_LO +: VW];
  assign new_amt   = ram_rdata[A_LO +: VW];
  assign hit       = rd_v_q && (ram_rdata[P_LO +: 16] == key_prod_q)
                     && (ram_rdata[T_LO +: 32] == key_time_q);
  assign ins_ask   = hit && (ram_rdata[S_B] == SIDE_ASK);
  assign ins_bid   = hit && (ram_rdata[S_B] == SIDE_BID);

  // ---------------------------------------------------------------- walk datapath
  assign out_free   = !out_valid_q || !out_stall_i;
  assign walk_end   = (na_q == '0) || (nb_q == '0) || (n_q == RES_CNT_W'(MAX_RESULTS));
  assign step       = walk_en && !walk_end && out_free;
  assign skip_ask   = (a_rem[0] == '0) && (rot_q == '0);
  assign trade      = (a_rem[0] != '0) && (b_rem[0] != '0) && (b_price[0] >= a_price[0]);
  assign amt        = (b_rem[0] >= a_rem[0]) ? a_rem[0] : b_rem[0];
  assign ask_rem_nx = trade ? (a_rem[0] - amt) : a_rem[0];
  assign bid_rem_nx = trade ? (b_rem[0] - amt) : b_rem[0];
  assign ask_done   = skip_ask || (rot_q == nb_q - CW'(1));
  assign rotate     = step && !skip_ask;
  assign advance_ask = step && ask_done;
  assign out_load   = (step && trade && pend_v_q) || flush_go;

  // neighbours and insert compares for the sorted cell rows
  for (genvar g = 0; g < ORDER_SLOTS; g++) begin : g_nb
    assign a_gt[g] = (CW'(g) < na_q) && (a_price[g] > new_price);
    assign b_lt[g] = (CW'(g) < nb_q) && (b_price[g] < new_price);
    if (g > 0) begin : g_prv
      assign a_pgt[g]   = a_gt[g-1];
      assign b_plt[g]   = b_lt[g-1];
      assign a_prv_p[g] = a_price[g-1];
      assign a_prv_r[g] = a_rem[g-1];
      assign b_prv_p[g] = b_price[g-1];
      assign b_prv_r[g] = b_rem[g-1];
    end else begin : g_prv0
      assign a_pgt[g]   = 1'b0;
      assign b_plt[g]   = 1'b0;
      assign a_prv_p[g] = '0;
      assign a_prv_r[g] = '0;
      assign b_prv_p[g] = '0;
      assign b_prv_r[g] = '0;
    end
    if (g < ORDER_SLOTS - 1) begin : g_nxt
      assign a_nxt_p[g] = a_price[g+1];
      assign a_nxt_r[g] = a_rem[g+1];
      assign b_nxt_p[g] = b_price[g+1];
      assign b_nxt_r[g] = b_rem[g+1];
    end else begin : g_nxt0
      assign a_nxt_p[g] = '0;
      assign a_nxt_r[g] = '0;
      assign b_nxt_p[g] = '0;
      assign b_nxt_r[g] = '0;
    end
  end

  // ask row ascends, bid row descends; equal prices keep arrival order
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < ORDER_SLOTS; k++) begin
      if (ins_ask) begin
        if (a_pgt[k]) begin
          a_price[k] <= a_prv_p[k];
          a_rem[k]   <= a_prv_r[k];
        end else if (a_gt[k] || (CW'(k) == na_q)) begin
          a_price[k] <= new_price;
          a_rem[k]   <= new_amt;
        end
      end else if (advance_ask) begin
        a_price[k] <= a_nxt_p[k];
        a_rem[k]   <= a_nxt_r[k];
      end else if (rotate && (k == 0)) begin
        a_rem[k] <= ask_rem_nx;
      end

      if (ins_bid) begin
        if (b_plt[k]) begin
          b_price[k] <= b_prv_p[k];
          b_rem[k]   <= b_prv_r[k];
        end else if (b_lt[k] || (CW'(k) == nb_q)) begin
          b_price[k] <= new_price;
          b_rem[k]   <= new_amt;
        end
      end else if (rotate) begin
        // move the head bid to the tail of the row
        if (CW'(k) == nb_q - CW'(1)) begin
          b_price[k] <= b_price[0];
          b_rem[k]   <= bid_rem_nx;
        end else begin
          b_price[k] <= b_nxt_p[k];
          b_rem[k]   <= b_nxt_r[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc && (operation_i == OP_MATCH)) state_d = ST_SCAN;
      ST_SCAN:  if ((rd_cnt_q == count_q) && !rd_v_q) state_d = ST_WALK;
      ST_WALK:  if (walk_end) state_d = ST_FLUSH;
      ST_FLUSH: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    walk_en    = 1'b0;
    flush_go   = 1'b0;
    match_go   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        match_go   = in_acc && (operation_i == OP_MATCH);
      end
      ST_SCAN:  ram_re   = (rd_cnt_q < count_q);
      ST_WALK:  walk_en  = 1'b1;
      ST_FLUSH: flush_go = out_free;
      default:  in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_cnt_q    <= '0;
      rd_v_q      <= 1'b0;
      na_q        <= '0;
      nb_q        <= '0;
      rot_q       <= '0;
      n_q         <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= ram_re;
      if (ram_we) begin
        count_q <= count_q + CW'(1);
      end
      if (match_go) begin
        rd_cnt_q <= '0;
        na_q     <= '0;
        nb_q     <= '0;
        rot_q    <= '0;
        n_q      <= '0;
        pend_v_q <= 1'b0;
      end else begin
        if (ram_re) begin
          rd_cnt_q <= rd_cnt_q + CW'(1);
        end
        if (ins_ask) begin
          na_q <= na_q + CW'(1);
        end else if (advance_ask) begin
          na_q <= na_q - CW'(1);
        end
        if (ins_bid) begin
          nb_q <= nb_q + CW'(1);
        end
        if (rotate) begin
          rot_q <= ask_done ? '0 : rot_q + CW'(1);
        end
        if (step && trade) begin
          n_q      <= n_q + RES_CNT_W'(1);
          pend_v_q <= 1'b1;
        end else if (flush_go) begin
          pend_v_q <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the latest sale until the next one shows it was not the last
  always_ff @(posedge clk_i) begin
    if (match_go) begin
      key_prod_q <= product_id_i;
      key_time_q <= time_id_i;
    end
    if (step && trade) begin
      pend_price_q <= a_price[0];
      pend_amt_q   <= amt;
    end
    if (out_load) begin
      if (flush_go) begin
        out_price_q <= pend_v_q ? 32'(pend_price_q) : '0;
        out_amt_q   <= pend_v_q ? 32'(pend_amt_q) : '0;
        out_sv_q    <= pend_v_q;
        out_last_q  <= 1'b1;
      end else begin
        out_price_q <= 32'(pend_price_q);
        out_amt_q   <= 32'(pend_amt_q);
        out_sv_q    <= 1'b1;
        out_last_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sale_price_o  = out_price_q;
  assign sale_amount_o = out_amt_q;
  assign sale_valid_o  = out_sv_q;
  assign last_sale_o   = out_last_q;

  // ---------------------------------------------------------------- checks
  `OBM_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(ORDER_SLOTS), "fill count overflow")
  `OBM_ASSERT(a_no_zero_sale, clk_i, rst_ni,
              (out_valid_o && sale_valid_o) |-> (sale_amount_o != '0), "zero-amount sale")
  `OBM_ASSERT(a_scan_drained, clk_i, rst_ni,
              (state_q == ST_WALK) |-> !rd_v_q, "walk began with a read in flight")
  `OBM_ASSERT(a_result_cap, clk_i, rst_ni,
              step |-> (n_q < RES_CNT_W'(MAX_RESULTS)), "sale beyond result cap")

endmodule

`default_nettype wire
